// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs no other file; each use passes a clock and an active-low reset name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TQP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tone_queue_player assertion failed");

// Next-cycle implication, switched off while reset is held.
`define TQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tone_queue_player assertion failed");

`endif

// File: sv/tqp_pkg.sv
// Shared types and constants of the tone queue player.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package tqp_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int PERIOD_W  = 16;
    localparam int QUEUED_W  = 7;
    localparam int CLK_HZ_W  = 32;
    localparam int PRESC_W   = 11;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Divisor 2 * freq * prescale and the shift-subtract divider around it.
    localparam int DEN_W      = FREQ_W + PRESC_W + 1;
    localparam int DIV_STEPS  = CLK_HZ_W;
    localparam int DIVCNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS  = 2'd2;

    localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RESET = 32'd24000000;
    localparam logic [PRESC_W-1:0]  PRESCALE_RESET = 11'd64;
    localparam logic [TICK_W-1:0]   TICK_MS_RESET  = 10'd10;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [FREQ_W-1:0] frequency;
        logic [DUR_W-1:0]  duration_ms;
    } in_item_t;

    typedef struct packed {
        logic                tone_on;
        logic [PERIOD_W-1:0] tone_period;
        logic                playing;
        logic [QUEUED_W-1:0] queued;
        logic                dropped;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic latch_item;
        logic exec;
        logic div_step;
        logic period_load;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: sv/tqp_ctrl.sv
// Sequencing state machine of the tone queue player.
// Depends on tqp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module tqp_ctrl
    import tqp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.period_load = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// File: sv/tqp_datapath.sv
// Datapath of the tone queue player: configuration, tone FIFO, player state,
// serial period divider and output register. Depends on tqp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqp_datapath
    import tqp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire in_item_t              s_item,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item
);

    // Configuration.
    logic [CLK_HZ_W-1:0] clock_hz_reg;
    logic [PRESC_W-1:0]  presc_reg;
    logic [TICK_W-1:0]   tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            presc_reg    <= PRESCALE_RESET;
            tick_reg     <= TICK_MS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_CLOCK_HZ: clock_hz_reg <= cfg_data;
                CFG_PRESCALE: presc_reg    <= cfg_data[PRESC_W-1:0];
                CFG_TICK_MS:  tick_reg     <= cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item held while it is worked on.
    in_item_t item_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_reg <= s_item;
        end
    end

    // Tone FIFO storage; entries are only read after being written.
    logic [FREQ_W-1:0] queue_freq_reg [QUEUE_DEPTH];
    logic [DUR_W-1:0]  queue_dur_reg  [QUEUE_DEPTH];

    logic [QIDX_W-1:0] head_reg, head_next;
    logic [QIDX_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              active_reg, active_next;
    logic [DUR_W-1:0]  active_dur_reg, active_dur_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic              running_reg, running_next;
    logic              out_en_reg, out_en_next;
    logic              dropped_reg, dropped_next;
    logic [PERIOD_W-1:0] period_reg;

    logic              fifo_write;
    logic [FREQ_W-1:0] head_freq;
    logic [DUR_W-1:0]  head_dur;
    logic              start_tone;
    logic              active_now;
    logic [DUR_W-1:0]  dur_now;
    logic [DUR_W-1:0]  elapsed_base;
    logic [DUR_W:0]    elapsed_sum;
    logic [DUR_W-1:0]  elapsed_sat;
    logic [QCNT_W-1:0] count_after;

    function automatic logic [QIDX_W-1:0] next_index(input logic [QIDX_W-1:0] idx);
        next_index = (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign head_freq = queue_freq_reg[head_reg];
    assign head_dur  = queue_dur_reg[head_reg];

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        active_dur_next = active_dur_reg;
        elapsed_next    = elapsed_reg;
        running_next    = running_reg;
        out_en_next     = out_en_reg;
        dropped_next    = dropped_reg;
        fifo_write      = 1'b0;

        start_tone   = !active_reg && (count_reg != '0);
        active_now   = active_reg || start_tone;
        dur_now      = start_tone ? head_dur : active_dur_reg;
        elapsed_base = start_tone ? '0 : elapsed_reg;
        elapsed_sum  = {1'b0, elapsed_base} + (DUR_W + 1)'(tick_reg);
        elapsed_sat  = elapsed_sum[DUR_W] ? '1 : elapsed_sum[DUR_W-1:0];
        count_after  = start_tone ? count_reg - 1'b1 : count_reg;

        if (cmd.exec) begin
            dropped_next = 1'b0;
            if (item_reg.operation == OP_ENQUEUE) begin
                if (count_reg < QCNT_W'(QUEUE_DEPTH)) begin
                    fifo_write = 1'b1;
                    tail_next  = next_index(tail_reg);
                    count_next = count_reg + 1'b1;
                end else begin
                    dropped_next = 1'b1;
                end
                running_next = 1'b1;
            end else if (running_reg) begin
                if (start_tone) begin
                    active_dur_next = head_dur;
                    head_next       = next_index(head_reg);
                    count_next      = count_after;
                    out_en_next     = (head_freq != '0);
                end
                if (!active_now) begin
                    out_en_next  = 1'b0;
                    running_next = 1'b0;
                end else if (elapsed_sat >= dur_now) begin
                    elapsed_next = '0;
                    active_next  = 1'b0;
                    if (count_after == '0) begin
                        out_en_next  = 1'b0;
                        running_next = 1'b0;
                    end
                end else begin
                    elapsed_next = elapsed_sat;
                    active_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_write) begin
            queue_freq_reg[tail_reg] <= item_reg.frequency;
            queue_dur_reg[tail_reg]  <= item_reg.duration_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            active_reg     <= 1'b0;
            active_dur_reg <= '0;
            elapsed_reg    <= '0;
            running_reg    <= 1'b0;
            out_en_reg     <= 1'b0;
            dropped_reg    <= 1'b0;
        end else begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            active_dur_reg <= active_dur_next;
            elapsed_reg    <= elapsed_next;
            running_reg    <= running_next;
            out_en_reg     <= out_en_next;
            dropped_reg    <= dropped_next;
        end
    end

    // A rest never reaches the divider, so only a tone start with a
    // non-zero frequency recomputes the period.
    assign sts.need_div = (item_reg.operation == OP_TICK) && running_reg && start_tone
                          && (head_freq != '0);

    // Restoring divider: clock_hz / (2 * freq * prescale), one quotient bit a cycle.
    logic [DEN_W-1:0]    den_reg;
    logic                den_zero_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [CLK_HZ_W-1:0] quo_reg;
    logic [DIVCNT_W-1:0] div_cnt_reg;
    logic [DEN_W:0]      rem_shift;
    logic [DEN_W:0]      rem_trial;
    logic                trial_ok;
    logic [DEN_W-2:0]    product;

    assign product   = (DEN_W - 1)'(head_freq) * (DEN_W - 1)'(presc_reg);
    assign rem_shift = {rem_reg, quo_reg[CLK_HZ_W-1]};
    assign rem_trial = rem_shift - {1'b0, den_reg};
    assign trial_ok  = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            den_reg      <= {product, 1'b0};
            den_zero_reg <= (product == '0);
            rem_reg      <= '0;
            quo_reg      <= clock_hz_reg;
            div_cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= trial_ok ? rem_trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg     <= {quo_reg[CLK_HZ_W-2:0], trial_ok};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign sts.div_last = (div_cnt_reg == DIVCNT_W'(DIV_STEPS - 1));

    logic [CLK_HZ_W-1:0] quo_minus;
    logic [PERIOD_W-1:0] period_calc;

    assign quo_minus = quo_reg - 1'b1;

    always_comb begin
        if (den_zero_reg) begin
            period_calc = '1;
        end else if (quo_reg == '0) begin
            period_calc = '0;
        end else if (quo_minus[CLK_HZ_W-1:PERIOD_W] != '0) begin
            period_calc = '1;
        end else begin
            period_calc = quo_minus[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
        end else if (cmd.period_load) begin
            period_reg <= period_calc;
        end
    end

    // Output register.
    logic      m_valid_reg;
    out_item_t m_item_reg;
    out_item_t result;

    assign result.tone_on     = out_en_reg;
    assign result.tone_period = period_reg;
    assign result.playing     = running_reg;
    assign result.queued      = QUEUED_W'(count_reg);
    assign result.dropped     = dropped_reg;

    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// File: sv/tone_queue_player.sv
// Tone queue player: a melody sequencer driving a square-wave buzzer timer.
// Input items on s_valid/s_ready carry an operation (enqueue or tick), a
// frequency and a duration; each item gives exactly one result item on
// m_valid/m_ready with the output enable, the half-period compare value,
// the running flag, the FIFO fill and a drop flag for refused enqueues.
// Configuration registers (clock in Hz, prescaler, ms per tick) are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high
// and writes are expected while the block is idle.
// One item is worked on at a time. An item without a period change goes
// from the execute state straight to the emit state; a tick that starts a
// sounding tone first runs the 32-step shift-subtract divider, one quotient
// bit per cycle, and then loads the period. The next item is accepted once
// the result of the last one has been emitted.
// A finished result waits in the output register while the receiver
// stalls; the block accepts the next item meanwhile but holds its own
// result until the register is free.
// Reset clears the FIFO pointers, the player state and the output register
// and restores the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module tone_queue_player
    import tqp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tqp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tqp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

// File: sv/tqp_checker.sv
// Port-level checker for the tone queue player, bound to the top level.
// Depends on tqp_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tqp_checker
    import tqp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    logic q_full;

    assign q_full = (m_item.queued == QUEUED_W'(QUEUE_DEPTH));

    // A stalled result item must hold.
    `TQP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // The buzzer is only enabled while the sequencer runs.
    `TQP_ASSERT_NOW(a_on_needs_run, aclk, aresetn, m_valid && m_item.tone_on, m_item.playing)

    // The fill never exceeds the FIFO depth.
    `TQP_ASSERT_NOW(a_fill_bound, aclk, aresetn, m_valid, m_item.queued <= QUEUED_W'(QUEUE_DEPTH))

    // A dropped enqueue means the FIFO was full and the player runs.
    `TQP_ASSERT_NOW(a_drop_full, aclk, aresetn, m_valid && m_item.dropped, q_full && m_item.playing)

endmodule

bind tone_queue_player tqp_checker u_tqp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
